// File: design/assert_macros.svh
// assertion macros shared by the cache directory rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// implication checked on every rising clock edge outside reset
`define ASSERT_CLK_IMPL(lbl, ante, cons, msg) \
   `ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

// File: design/lcl_pkg.sv
// package of types and constants for the lru cache lookup block
package lcl_pkg;

   localparam int ENTRIES = 64;
   localparam int KEY_W   = 64;
   localparam int CAP_W   = 7;
   localparam int OCC_W   = 7;
   localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

   typedef struct packed {
      logic             hit;
      logic [OCC_W-1:0] occupancy;
   } lcl_result_type;

endpackage

// File: design/lcl_directory.sv
// fully associative key directory with age ranks and lru replacement
`include "assert_macros.svh"

module lcl_directory (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        lookup_en,
   input  logic [lcl_pkg::KEY_W-1:0]   lookup_key,
   input  logic [lcl_pkg::CAP_W-1:0]   capacity,
   output lcl_pkg::lcl_result_type     result
);

   import lcl_pkg::*;

   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   logic [KEY_W-1:0]  keys_ff [ENTRIES];
   logic [RANK_W-1:0] rank_ff [ENTRIES];
   logic [RANK_W-1:0] rank_in [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;
   logic [CNT_W-1:0]   used_ff;
   logic [CNT_W-1:0]   used_in;

   logic [ENTRIES-1:0] hit_vec;
   logic [ENTRIES-1:0] victim_vec;
   logic [ENTRIES-1:0] free_vec;
   logic [ENTRIES-1:0] invalid_vec;
   logic [ENTRIES-1:0] write_vec;
   logic [RANK_W-1:0]  hit_rank;
   logic [RANK_W-1:0]  oldest_rank;
   logic [CMP_W-1:0]   cap_ext;
   logic [CMP_W-1:0]   eff_cap;
   logic               any_hit;
   logic               used_full;
   logic               do_evict;
   logic               do_insert;

   // capacity clamped to one..entries
   always_comb begin
      cap_ext = CMP_W'(capacity);
      if (cap_ext == CMP_W'(0)) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign used_full   = CMP_W'(used_ff) >= eff_cap;
   assign oldest_rank = RANK_W'(used_ff - CNT_W'(1));
   assign invalid_vec = ~valid_ff;
   // lowest free entry
   assign free_vec    = invalid_vec & (~invalid_vec + ENTRIES'(1));
   assign any_hit     = |hit_vec;
   assign do_evict    = !any_hit && used_full;
   assign do_insert   = !any_hit && !used_full;

   always_comb begin
      hit_rank = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i]    = valid_ff[i] && (keys_ff[i] == lookup_key);
         victim_vec[i] = valid_ff[i] && (rank_ff[i] == oldest_rank);
         if (hit_vec[i]) begin
            hit_rank = hit_rank | rank_ff[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         logic age;
         logic sel;
         if (any_hit) begin
            age = valid_ff[i] && (rank_ff[i] < hit_rank);
         end else if (do_evict) begin
            age = valid_ff[i] && (rank_ff[i] < oldest_rank);
         end else begin
            age = valid_ff[i];
         end
         sel = hit_vec[i] || (do_evict && victim_vec[i]) || (do_insert && free_vec[i]);
         write_vec[i] = (do_evict && victim_vec[i]) || (do_insert && free_vec[i]);
         if (sel) begin
            rank_in[i] = '0;
         end else if (age) begin
            rank_in[i] = rank_ff[i] + RANK_W'(1);
         end else begin
            rank_in[i] = rank_ff[i];
         end
      end
      valid_in = valid_ff | (do_insert ? free_vec : '0);
      used_in  = do_insert ? used_ff + CNT_W'(1) : used_ff;
   end

   assign result.hit       = any_hit;
   assign result.occupancy = OCC_W'(used_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         used_ff  <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (lookup_en) begin
         valid_ff <= valid_in;
         used_ff  <= used_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (lookup_en && write_vec[i]) begin
            keys_ff[i] <= lookup_key;
         end
      end
   end

   `ASSERT_CLK(a_count_matches_valid, $countones(valid_ff) == int'(used_ff), "count mismatch")
   `ASSERT_CLK(a_count_in_range, int'(used_ff) <= ENTRIES, "count above entries")
   `ASSERT_CLK(a_single_hit, $onehot0(hit_vec), "duplicate key in directory")
   `ASSERT_CLK_IMPL(a_hit_keeps_count, lookup_en && any_hit, ##1 $stable(used_ff), "hit changed count")
   `ASSERT_CLK_IMPL(a_evict_has_victim, lookup_en && do_evict, $onehot(victim_vec), "no unique lru entry")

endmodule

// File: design/lru_cache_lookup_top.sv
// top level of the lru cache lookup block: handshakes, capacity register, result register
//
// Fully associative directory of 64-bit page keys with least-recently-used
// replacement. One request is accepted per clock cycle, back to back; its key is
// held in the request stage register and its result is then presented by the result
// register until taken. A result held by the receiver stops the request side once
// the request stage is also occupied. Every stored key is compared in parallel and
// all age ranks are updated in the same cycle, so each request sees the directory
// left by the one before it. The directory starts empty after reset. csr_capacity
// sets how many entries may fill (zero acts as one, values above the entry count
// act as the entry count); write it only while no request is in flight. Lowering
// it below the current occupancy flushes nothing.

module lru_cache_lookup_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [lcl_pkg::KEY_W-1:0]   req_page_key,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_hit,
   output logic [lcl_pkg::OCC_W-1:0]   rsp_occupancy,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lcl_pkg::CAP_W-1:0]   csr_capacity
);

   import lcl_pkg::*;

   logic                 stage_valid_ff;
   logic [KEY_W-1:0]     stage_key_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [OCC_W-1:0]     rsp_occupancy_ff;
   logic [CAP_W-1:0]     capacity_ff;
   logic                 advance;
   logic                 lookup_en;
   lcl_result_type       dir_result;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign lookup_en = stage_valid_ff && advance;
   assign req_ready = !stage_valid_ff || advance;
   assign csr_ready = 1'b1;

   lcl_directory u_directory (
      .clock      (clock),
      .reset      (reset),
      .lookup_en  (lookup_en),
      .lookup_key (stage_key_ff),
      .capacity   (capacity_ff),
      .result     (dir_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         capacity_ff    <= CAP_RESET;
      end else begin
         if (req_ready) begin
            stage_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= stage_valid_ff;
         end
         if (csr_valid) begin
            capacity_ff <= csr_capacity;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_key_ff <= req_page_key;
      end
      if (lookup_en) begin
         rsp_hit_ff       <= dir_result.hit;
         rsp_occupancy_ff <= dir_result.occupancy;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_occupancy = rsp_occupancy_ff;

endmodule

// File: tb/lcl_checker.sv
// checker for the lru cache lookup block: tracks the directory, predicts and compares responses
module lcl_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [lcl_pkg::KEY_W-1:0]   req_page_key,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic                        rsp_hit,
   input  logic [lcl_pkg::OCC_W-1:0]   rsp_occupancy,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [lcl_pkg::CAP_W-1:0]   csr_capacity,
   output int                          error_count,
   output int                          answers_due
);
   timeunit 1ns;
   timeprecision 1ps;

   import lcl_pkg::*;

   logic [KEY_W-1:0]  dir_key [ENTRIES];
   logic              dir_valid [ENTRIES];
   logic [RANK_W-1:0] dir_rank [ENTRIES];
   logic [CNT_W-1:0]  dir_used;
   logic [CAP_W-1:0]  dir_cap;

   lcl_result_type    lookup_answers [$];

   function automatic void age_below(input int limit);
      for (int i = 0; i < ENTRIES; i++)
         if (dir_valid[i] && int'(dir_rank[i]) < limit)
            dir_rank[i] = dir_rank[i] + 1'b1;
   endfunction

   function automatic lcl_result_type lookup_page(input logic [KEY_W-1:0] key);
      lcl_result_type    res;
      int                slot;
      int                victim;
      int                eff_cap;
      bit                found;
      logic [RANK_W-1:0] oldest;
      slot = -1;
      victim = 0;
      found = 0;
      oldest = '0;
      res.hit = 1'b0;
      eff_cap = (dir_cap == 0) ? 1 : ((int'(dir_cap) > ENTRIES) ? ENTRIES : int'(dir_cap));
      for (int i = 0; i < ENTRIES; i++) begin
         if (dir_valid[i] && dir_key[i] == key) begin
            slot = i;
            break;
         end
      end
      if (slot >= 0) begin
         age_below(int'(dir_rank[slot]));
         dir_rank[slot] = '0;
         res.hit = 1'b1;
      end else if (int'(dir_used) >= eff_cap) begin
         // evict least recently used
         for (int i = 0; i < ENTRIES; i++) begin
            if (dir_valid[i] && (!found || dir_rank[i] > oldest)) begin
               oldest = dir_rank[i];
               victim = i;
               found = 1;
            end
         end
         if (found) begin
            age_below(int'(oldest));
            dir_key[victim] = key;
            dir_rank[victim] = '0;
         end
      end else begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (!dir_valid[i]) begin
               slot = i;
               break;
            end
         end
         if (slot >= 0) begin
            age_below(ENTRIES + 1);
            dir_key[slot] = key;
            dir_valid[slot] = 1'b1;
            dir_rank[slot] = '0;
            dir_used = dir_used + 1'b1;
         end
      end
      res.occupancy = OCC_W'(dir_used);
      return res;
   endfunction

   always @(posedge clock) begin
      lcl_result_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            dir_key[i] = '0;
            dir_valid[i] = 1'b0;
            dir_rank[i] = '0;
         end
         dir_used = '0;
         dir_cap = CAP_RESET;
         lookup_answers.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (lookup_answers.size() == 0) begin
               $error("unexpected response: hit %0d occupancy %0d", rsp_hit, rsp_occupancy);
               error_count = error_count + 1;
            end else begin
               want = lookup_answers.pop_front();
               if (rsp_hit !== want.hit) begin
                  $error("hit mismatch: expected %0d actual %0d", want.hit, rsp_hit);
                  error_count = error_count + 1;
               end
               if (rsp_occupancy !== want.occupancy) begin
                  $error("occupancy mismatch: expected %0d actual %0d",
                         want.occupancy, rsp_occupancy);
                  error_count = error_count + 1;
               end
            end
         end
         if (req_valid && req_ready)
            lookup_answers.push_back(lookup_page(req_page_key));
         if (csr_valid && csr_ready)
            dir_cap = csr_capacity;
      end
      answers_due = lookup_answers.size();
   end

endmodule

// File: tb/tb_lru_cache_lookup_top.sv
// testbench top for the lru cache lookup block: clock, reset, request stimulus and verdict
module tb_lru_cache_lookup_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lcl_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS     = 105;
   localparam int POOL_MAX        = 160;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [KEY_W-1:0]   req_page_key = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_hit;
   logic [OCC_W-1:0]   rsp_occupancy;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CAP_W-1:0]   csr_capacity = '0;

   int                 error_count;
   int                 answers_due;
   int                 cycle_count = 0;
   logic               no_idle = 1'b0;
   logic               stall_phase = 1'b0;

   logic [KEY_W-1:0]   key_pool [POOL_MAX];
   int                 pool_size = 1;

   lru_cache_lookup_top DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_page_key  (req_page_key),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_hit       (rsp_hit),
      .rsp_occupancy (rsp_occupancy),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_capacity  (csr_capacity)
   );

   lcl_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_page_key  (req_page_key),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_hit       (rsp_hit),
      .rsp_occupancy (rsp_occupancy),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_capacity  (csr_capacity),
      .error_count   (error_count),
      .answers_due   (answers_due)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // response side, with one long hold-off during the stall phase
   initial begin : rsp_side
      bit held;
      held = 0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (stall_phase && !held) begin
            held = 1;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(0, 99) >= 21);
         end
      end
   end

   task automatic send_key(input logic [KEY_W-1:0] key);
      if (!no_idle) begin
         while ($urandom_range(0, 99) < 21) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_page_key <= key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (answers_due != 0);
      @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      int eff_cap;
      wait_idle();
      csr_valid <= 1'b1;
      csr_capacity <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      eff_cap = (cap == 0) ? 1 : ((int'(cap) > ENTRIES) ? ENTRIES : int'(cap));
      pool_size = eff_cap + $urandom_range(1, eff_cap + 2);
      if (pool_size > POOL_MAX)
         pool_size = POOL_MAX;
      for (int i = 0; i < pool_size; i++)
         key_pool[i] = {$urandom, $urandom};
   endtask

   // mostly reused keys so that hits and evictions both happen
   function automatic logic [KEY_W-1:0] pick_key();
      int sel;
      logic [KEY_W-1:0] one_bit;
      sel = $urandom_range(0, 99);
      one_bit = KEY_W'(1) << $urandom_range(0, KEY_W - 1);
      if (sel < 75)
         return key_pool[$urandom_range(0, pool_size - 1)];
      else if (sel < 85)
         return key_pool[$urandom_range(0, pool_size - 1)] ^ one_bit;
      else if (sel < 96)
         return {$urandom, $urandom};
      else if (sel < 98)
         return '0;
      else
         return '1;
   endfunction

   initial begin
      logic [CAP_W-1:0] phase_caps [10];
      phase_caps = '{7'd5, 7'd1, 7'd16, 7'd33, 7'd127, 7'd64, 7'd0, 7'd0, 7'd8, 7'd0};
      phase_caps[6] = CAP_W'($urandom_range(0, 127));
      phase_caps[7] = CAP_W'($urandom_range(0, 127));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // capacity zero acts as one
      write_capacity('0);
      send_key('0);
      send_key('0);
      send_key('1);
      send_key('1);
      send_key('0);
      send_key('0);

      write_capacity(7'd2);
      send_key('1);
      send_key('0);
      send_key({1'b1, {(KEY_W-1){1'b0}}});
      send_key('1);
      send_key(64'h1);
      send_key(64'h1);
      send_key({1'b1, {(KEY_W-1){1'b0}}});
      send_key(64'h5555_5555_5555_5555);
      send_key(64'hAAAA_AAAA_AAAA_AAAA);
      send_key(64'h5555_5555_5555_5555);

      for (int p = 0; p < 10; p++) begin
         write_capacity(phase_caps[p]);
         stall_phase <= (p == 3);
         no_idle <= (p == 5);
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_key(pick_key());
      end
      stall_phase <= 1'b0;
      no_idle <= 1'b0;

      wait_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
